@@ rtl/cfws_pkg.sv @@
// ----------------------------------------------------------------------------
// cfws_pkg
// Shared types and constants for the circular FIFO with search.
// ----------------------------------------------------------------------------
package cfws_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [2:0] OP_INSERT   = 3'd0;
    localparam logic [2:0] OP_DELETE   = 3'd1;
    localparam logic [2:0] OP_COUNT    = 3'd2;
    localparam logic [2:0] OP_SEARCH   = 3'd3;
    localparam logic [2:0] OP_TRAVERSE = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic               found;
        logic [4:0]         occupancy;
        logic               last;
    } t_res;

    // cell update modes, broadcast to every cell
    typedef enum logic [1:0] {
        MODE_HOLD   = 2'd0,
        MODE_LOAD   = 2'd1,
        MODE_SHIFT  = 2'd2,
        MODE_ROTATE = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode mode;
    } t_cell_ctl;

endpackage

@@ rtl/cfws_cell.sv @@
// ----------------------------------------------------------------------------
// cfws_cell
// One queue entry. Cell 0 holds the head; entries move toward cell 0.
// ----------------------------------------------------------------------------
module cfws_cell
    import cfws_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FW         = 5,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [FW-1:0]         i_fill,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_next,
    input  logic [DATA_WIDTH-1:0] i_head,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.mode)
            MODE_HOLD: begin
                n_data = r_data;
            end
            MODE_LOAD: begin
                if (i_fill == FW'(IDX)) begin
                    n_data = i_value;
                end
            end
            MODE_SHIFT: begin
                n_data = i_next;
            end
            MODE_ROTATE: begin
                // last occupied cell takes the head back
                if (i_fill == FW'(IDX + 1)) begin
                    n_data = i_head;
                end else begin
                    n_data = i_next;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ rtl/circular_fifo_with_search.sv @@
// ----------------------------------------------------------------------------
// circular_fifo_with_search
// Fixed-depth FIFO built as a row of cells, with count, search and traverse.
// ----------------------------------------------------------------------------
// Insert, delete and count never raise busy, and the result
// strobes on o_valid in the cycle after start. Search and traverse rotate the
// occupied cells past cell 0 once, one entry per cycle, keeping busy high
// while they run; traverse emits one result per cycle, search emits its
// single result after the last entry has passed.
// On an empty queue they return a result without going busy. Results are never held off.
// ----------------------------------------------------------------------------
module circular_fifo_with_search
    import cfws_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_valid,
    output t_res o_res
);

    localparam int FW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_TRAV   = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [FW-1:0]         r_fill,  n_fill;
    logic [FW-1:0]         r_cnt,   n_cnt;
    logic [DATA_WIDTH-1:0] r_key,   n_key;
    logic                  r_hit,   n_hit;
    logic                  r_valid, n_valid;
    t_res                  r_res,   n_res;

    t_cell_ctl             w_ctl;
    logic [DATA_WIDTH-1:0] w_value;
    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [DATA_WIDTH-1:0] w_next [DEPTH];
    logic                  w_hit;

    assign w_value = DATA_WIDTH'($unsigned(i_req.value));
    assign w_hit   = r_hit | (w_data[0] == r_key);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            if (gi == DEPTH - 1) begin : g_end
                assign w_next[gi] = w_data[gi];
            end else begin : g_mid
                assign w_next[gi] = w_data[gi+1];
            end
            cfws_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .FW         (FW),
                .IDX        (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_fill  (r_fill),
                .i_value (w_value),
                .i_next  (w_next[gi]),
                .i_head  (w_data[0]),
                .o_data  (w_data[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state        = r_state;
        n_fill         = r_fill;
        n_cnt          = r_cnt;
        n_key          = r_key;
        n_hit          = r_hit;
        n_valid        = 1'b0;
        n_res          = r_res;
        w_ctl.mode     = MODE_HOLD;
        n_res.status   = ST_OK;
        n_res.data     = '0;
        n_res.found    = 1'b0;
        n_res.occupancy = 5'(r_fill);
        n_res.last     = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_req.op)
                        OP_INSERT: begin
                            n_valid = 1'b1;
                            if (r_fill == FW'(DEPTH)) begin
                                n_res.status = ST_OVERFLOW;
                            end else begin
                                w_ctl.mode      = MODE_LOAD;
                                n_fill          = r_fill + FW'(1);
                                n_res.occupancy = 5'(n_fill);
                            end
                        end
                        OP_DELETE: begin
                            n_valid = 1'b1;
                            if (r_fill == '0) begin
                                n_res.status = ST_UNDERFLOW;
                            end else begin
                                w_ctl.mode      = MODE_SHIFT;
                                n_fill          = r_fill - FW'(1);
                                n_res.data      = 32'(w_data[0]);
                                n_res.occupancy = 5'(n_fill);
                            end
                        end
                        OP_COUNT: begin
                            n_valid = 1'b1;
                        end
                        OP_SEARCH: begin
                            if (r_fill == '0) begin
                                n_valid = 1'b1;
                            end else begin
                                n_state = S_SEARCH;
                                n_cnt   = r_fill;
                                n_key   = w_value;
                                n_hit   = 1'b0;
                            end
                        end
                        OP_TRAVERSE: begin
                            if (r_fill == '0) begin
                                n_valid      = 1'b1;
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_state = S_TRAV;
                                n_cnt   = r_fill;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                w_ctl.mode = MODE_ROTATE;
                n_hit      = w_hit;
                n_cnt      = r_cnt - FW'(1);
                if (r_cnt == FW'(1)) begin
                    n_valid     = 1'b1;
                    n_res.found = w_hit;
                    n_state     = S_IDLE;
                end
            end
            S_TRAV: begin
                w_ctl.mode = MODE_ROTATE;
                n_cnt      = r_cnt - FW'(1);
                n_valid    = 1'b1;
                n_res.data = 32'(w_data[0]);
                n_res.last = (r_cnt == FW'(1));
                if (r_cnt == FW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_cnt   <= '0;
            r_hit   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
            r_hit   <= n_hit;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_res <= n_res;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
